// File: design/fmpd_pkg.sv
// ============================================================================
// fmpd_pkg - FM phase discriminator shared definitions
// Widths, angle constants, the arctangent table and the sequencer state type
// used by the discriminator and its channel interfaces.
// ============================================================================
package fmpd_pkg;

   // Default configuration
   localparam int SAMPLE_WIDTH_DEF = 8;
   localparam int CORDIC_STEPS_DEF = 16;

   // Arctangent table depth and index width
   localparam int MAX_STEPS   = 24;
   localparam int TABLE_IDX_W = 5;

   // Output phase word
   localparam int PHASE_W = 16;

   // Rotator datapath: operands normalized to 2^39, gain and sign need headroom
   localparam int NORM_EXP = 40;
   localparam int CORDIC_W = 44;

   // Angle accumulator in units of pi * 2^-24
   localparam int ANGLE_W   = 28;
   localparam int ROUND_SH  = 9;
   localparam logic signed [ANGLE_W-1:0] ANGLE_PI   = ANGLE_W'(16777216);
   localparam logic signed [ANGLE_W-1:0] ROUND_BIAS = ANGLE_W'(256);
   localparam logic signed [ANGLE_W-1:0] SAT_HI     = ANGLE_W'(32767);
   localparam logic signed [ANGLE_W-1:0] SAT_LO     = ANGLE_W'(-32768);

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PREP,
      ST_ROT,
      ST_DONE
   } fmpd_state_type;

   // atan(2^-k) in units of pi * 2^-24
   function automatic logic signed [ANGLE_W-1:0] atan_entry(
      input logic [TABLE_IDX_W-1:0] idx
   );
      logic signed [ANGLE_W-1:0] val;
      case (idx)
         5'd0:    val = ANGLE_W'(4194304);
         5'd1:    val = ANGLE_W'(2476042);
         5'd2:    val = ANGLE_W'(1308273);
         5'd3:    val = ANGLE_W'(664100);
         5'd4:    val = ANGLE_W'(333339);
         5'd5:    val = ANGLE_W'(166832);
         5'd6:    val = ANGLE_W'(83436);
         5'd7:    val = ANGLE_W'(41721);
         5'd8:    val = ANGLE_W'(20861);
         5'd9:    val = ANGLE_W'(10430);
         5'd10:   val = ANGLE_W'(5215);
         5'd11:   val = ANGLE_W'(2608);
         5'd12:   val = ANGLE_W'(1304);
         5'd13:   val = ANGLE_W'(652);
         5'd14:   val = ANGLE_W'(326);
         5'd15:   val = ANGLE_W'(163);
         5'd16:   val = ANGLE_W'(81);
         5'd17:   val = ANGLE_W'(41);
         5'd18:   val = ANGLE_W'(20);
         5'd19:   val = ANGLE_W'(10);
         5'd20:   val = ANGLE_W'(5);
         5'd21:   val = ANGLE_W'(3);
         5'd22:   val = ANGLE_W'(1);
         5'd23:   val = ANGLE_W'(1);
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// File: design/fmpd_req_if.sv
// ============================================================================
// fmpd_req_if - sample request channel
// Valid/ready channel carrying one complex baseband sample and a block flag.
// ============================================================================
interface fmpd_req_if #(
   parameter int SAMPLE_WIDTH = fmpd_pkg::SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] i_sample;
   logic signed [SAMPLE_WIDTH-1:0] q_sample;
   logic                           block_start;

   modport source (output valid, output i_sample, output q_sample, output block_start,
                   input ready);
   modport sink   (input valid, input i_sample, input q_sample, input block_start,
                   output ready);
endinterface

// File: design/fmpd_rsp_if.sv
// ============================================================================
// fmpd_rsp_if - phase step response channel
// Valid/ready channel carrying one Q15 phase step.
// ============================================================================
interface fmpd_rsp_if;
   import fmpd_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [PHASE_W-1:0] phase_step;

   modport source (output valid, output phase_step, input ready);
   modport sink   (input valid, input phase_step, output ready);
endinterface

// File: design/fm_phase_discriminator_top.sv
// ============================================================================
// fm_phase_discriminator_top - polar FM discriminator
// Multiplies each sample by the conjugate of the previous one and takes the
// angle of the product with an iterative CORDIC, giving the phase step as a
// Q15 fraction of pi.
// ============================================================================
//
//  Channel   Dir  Payload                               Transfer
//  req_chan  in   i_sample, q_sample, block_start       valid & ready
//  rsp_chan  out  phase_step (Q15 of pi)                valid & ready
//
//  After a sample transfer the sequencer forms the products in turn on
//  one multiplier, sets up the rotator, runs the rotations at one per
//  cycle in the shared rotate unit and rounds the angle in the rounding
//  state, where it waits for a free output register; rsp valid then rises.
//  The sequencer is idle again as rsp valid rises; no new sample is taken
//  before the last one is through. A zero product skips the rotations.
//  A block-start sample (or the first after reset) only becomes history.
//  req_chan.ready is high only while the sequencer is idle; a result held
//  on rsp_chan does not block the next transfer, but the following result
//  waits in the rounding cycle until the output register is free.
//  Reset is synchronous and clears the sequencer, the history and rsp valid.
//
module fm_phase_discriminator_top #(
   parameter int SAMPLE_WIDTH = fmpd_pkg::SAMPLE_WIDTH_DEF,
   parameter int CORDIC_STEPS = fmpd_pkg::CORDIC_STEPS_DEF
) (
   input logic         clock,
   input logic         reset,
   fmpd_req_if.sink    req_chan,
   fmpd_rsp_if.source  rsp_chan
);
   import fmpd_pkg::*;

   localparam int STEPS_EFF = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
   localparam int STEP_W    = $clog2(STEPS_EFF);
   localparam int PROD_W    = 2 * SAMPLE_WIDTH + 1;
   localparam int SCALE_SH  = NORM_EXP - 2 * SAMPLE_WIDTH;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEPS_EFF - 1);

   // Control state
   fmpd_state_type     state_ff, state_in;
   logic               have_prev_ff, have_prev_in;
   logic [1:0]         mul_cnt_ff, mul_cnt_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic signed [SAMPLE_WIDTH-1:0] prev_i_ff, prev_i_in;
   logic signed [SAMPLE_WIDTH-1:0] prev_q_ff, prev_q_in;
   logic signed [SAMPLE_WIDTH-1:0] cur_i_ff, cur_i_in;
   logic signed [SAMPLE_WIDTH-1:0] cur_q_ff, cur_q_in;
   logic signed [PROD_W-1:0]       acc_ff, acc_in;
   logic signed [PROD_W-1:0]       re_ff, re_in;
   logic signed [PROD_W-1:0]       im_ff, im_in;
   logic signed [CORDIC_W-1:0]     x_ff, x_in;
   logic signed [CORDIC_W-1:0]     y_ff, y_in;
   logic signed [ANGLE_W-1:0]      z_ff, z_in;
   logic signed [PHASE_W-1:0]      phase_ff, phase_in;

   // Datapath nets
   logic                              req_xfer;
   logic signed [SAMPLE_WIDTH-1:0]    mul_a, mul_b;
   logic signed [2*SAMPLE_WIDTH-1:0]  prod;
   logic signed [PROD_W-1:0]          mac_sum, mac_diff;
   logic signed [CORDIC_W-1:0]        x_scaled, y_scaled;
   logic signed [CORDIC_W-1:0]        x_shift, y_shift;
   logic signed [ANGLE_W-1:0]         atan_k;
   logic signed [ANGLE_W-1:0]         z_round;
   logic                              out_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.phase_step = phase_ff;
   assign out_free            = !rsp_valid_ff || rsp_chan.ready;

   // Shared multiplier: prev_i*cur_i, prev_q*cur_q, prev_i*cur_q, prev_q*cur_i
   assign mul_a    = mul_cnt_ff[0] ? prev_q_ff : prev_i_ff;
   assign mul_b    = (mul_cnt_ff[0] ^ mul_cnt_ff[1]) ? cur_q_ff : cur_i_ff;
   assign prod     = mul_a * mul_b;
   assign mac_sum  = acc_ff + PROD_W'(prod);
   assign mac_diff = acc_ff - PROD_W'(prod);

   // Normalize product to the rotator's fixed scale
   assign x_scaled = CORDIC_W'(re_ff) <<< SCALE_SH;
   assign y_scaled = CORDIC_W'(im_ff) <<< SCALE_SH;

   // Shared rotate unit operands
   assign x_shift = x_ff >>> step_ff;
   assign y_shift = y_ff >>> step_ff;
   assign atan_k  = atan_entry(TABLE_IDX_W'(step_ff));

   // Round to Q15 (floor after half-LSB bias)
   assign z_round = (z_ff + ROUND_BIAS) >>> ROUND_SH;

   // Sequencer: next state and datapath updates
   always_comb begin
      state_in     = state_ff;
      have_prev_in = have_prev_ff;
      mul_cnt_in   = mul_cnt_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      prev_i_in    = prev_i_ff;
      prev_q_in    = prev_q_ff;
      cur_i_in     = cur_i_ff;
      cur_q_in     = cur_q_ff;
      acc_in       = acc_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      phase_in     = phase_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_chan.block_start || !have_prev_ff) begin
                  // Store as new history, no result
                  prev_i_in    = req_chan.i_sample;
                  prev_q_in    = req_chan.q_sample;
                  have_prev_in = 1'b1;
               end else begin
                  cur_i_in   = req_chan.i_sample;
                  cur_q_in   = req_chan.q_sample;
                  mul_cnt_in = '0;
                  state_in   = ST_MUL;
               end
            end
         end

         ST_MUL: begin
            // Accumulate real part, then imaginary part
            unique case (mul_cnt_ff)
               2'd0:    acc_in = PROD_W'(prod);
               2'd1:    re_in  = mac_sum;
               2'd2:    acc_in = PROD_W'(prod);
               2'd3:    im_in  = mac_diff;
               default: acc_in = acc_ff;
            endcase
            mul_cnt_in = mul_cnt_ff + 2'd1;
            if (mul_cnt_ff == 2'd3) begin
               // Advance history once the products are formed
               prev_i_in = cur_i_ff;
               prev_q_in = cur_q_ff;
               state_in  = ST_PREP;
            end
         end

         ST_PREP: begin
            step_in = '0;
            if (re_ff == '0 && im_ff == '0) begin
               z_in     = '0;
               state_in = ST_DONE;
            end else if (re_ff[PROD_W-1]) begin
               // Left half plane: turn by pi first
               x_in     = -x_scaled;
               y_in     = -y_scaled;
               z_in     = im_ff[PROD_W-1] ? -ANGLE_PI : ANGLE_PI;
               state_in = ST_ROT;
            end else begin
               x_in     = x_scaled;
               y_in     = y_scaled;
               z_in     = '0;
               state_in = ST_ROT;
            end
         end

         ST_ROT: begin
            // One CORDIC vectoring step toward y = 0
            if (!y_ff[CORDIC_W-1]) begin
               x_in = x_ff + y_shift;
               y_in = y_ff - x_shift;
               z_in = z_ff + atan_k;
            end else begin
               x_in = x_ff - y_shift;
               y_in = y_ff + x_shift;
               z_in = z_ff - atan_k;
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            // Hold until the output register is free, then load the result
            if (out_free) begin
               priority if (z_round > SAT_HI) begin
                  phase_in = PHASE_W'(SAT_HI);
               end else if (z_round < SAT_LO) begin
                  phase_in = PHASE_W'(SAT_LO);
               end else begin
                  phase_in = PHASE_W'(z_round);
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         have_prev_ff <= 1'b0;
         mul_cnt_ff   <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         prev_i_ff    <= '0;
         prev_q_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         have_prev_ff <= have_prev_in;
         mul_cnt_ff   <= mul_cnt_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_i_ff    <= prev_i_in;
         prev_q_ff    <= prev_q_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_i_ff <= cur_i_in;
      cur_q_ff <= cur_q_in;
      acc_ff   <= acc_in;
      re_ff    <= re_in;
      im_ff    <= im_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      phase_ff <= phase_in;
   end

   // A new result only comes out of the rounding cycle
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("rsp valid rose without a finished rotation");

   // Rotation counter never passes the last table entry
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT) |-> (step_ff <= STEP_LAST))
      else $error("rotation step out of range");

   // A finished result waits while the output register is still occupied
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_valid_ff && !rsp_chan.ready)
         |=> (state_ff == ST_DONE) && $stable(phase_ff))
      else $error("result overwrote a pending transfer");

   // A zero product skips rotation with a zero angle
   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PREP && re_ff == '0 && im_ff == '0)
         |=> (state_ff == ST_DONE) && (z_ff == '0))
      else $error("zero vector did not give zero phase");

endmodule
